// File: rtl/core/text_substring_search_core_defines.svh
// Assertion macros for the substring search core.
`ifndef TEXT_SUBSTRING_SEARCH_CORE_DEFINES_SVH
`define TEXT_SUBSTRING_SEARCH_CORE_DEFINES_SVH

`ifndef SYNTHESIS
// check gated off while reset is asserted
`define TSS_ASSERT_RUN(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error(msg);
// check that must also hold through reset
`define TSS_ASSERT_ALL(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) \
    else $error(msg);
`else
`define TSS_ASSERT_RUN(label, clk, rst_n, prop, msg)
`define TSS_ASSERT_ALL(label, clk, prop, msg)
`endif

`endif

// File: rtl/core/tss_pkg.sv
// Constants, types and helper functions for the substring search core.
package tss_pkg;

  localparam int PATTERN_MAX = 16;
  localparam int PAT_BYTES   = 16;
  localparam int WIN_IDX_W   = $clog2(PATTERN_MAX);
  localparam int TEXT_MAX    = 1048576;
  localparam int POS_W       = 20;
  localparam int CNT_W       = 21;
  localparam int PAT_LEN_W   = 5;
  localparam int ADDR_W      = 6;
  localparam int DATA_W      = 64;

  localparam logic [7:0] CASE_FOLD_LIMIT = 8'h80;
  localparam logic [7:0] ASCII_UPPER_A   = 8'h41;
  localparam logic [7:0] ASCII_UPPER_Z   = 8'h5A;
  localparam logic [7:0] ASCII_CASE_OFS  = 8'h20;

  typedef enum logic [2:0] {
    REG_PAT_LO    = 3'd0,
    REG_PAT_HI    = 3'd1,
    REG_PAT_LEN   = 3'd2,
    REG_CASE_SENS = 3'd3,
    REG_BACKWARD  = 3'd4,
    REG_WRAP      = 3'd5,
    REG_SEL_START = 3'd6,
    REG_SEL_END   = 3'd7
  } cfg_reg_t;

  typedef struct packed {
    logic             valid;
    logic [POS_W-1:0] pos;
  } hit_t;

  typedef struct packed {
    logic             hit;
    logic [POS_W-1:0] start;
    logic             start_ge_end;
    logic             end_le_end;
    logic             end_le_start;
    logic             past_end;
    logic             ovf;
    logic             last;
  } s1_word_t;

  function automatic logic [7:0] fold_byte(input logic [7:0] b, input logic case_sens);
    logic [7:0] r;
    r = b;
    if (!case_sens && b < CASE_FOLD_LIMIT && b >= ASCII_UPPER_A && b <= ASCII_UPPER_Z) begin
      r = b + ASCII_CASE_OFS;
    end
    return r;
  endfunction

  function automatic logic [7:0] pattern_byte(input logic [63:0] lo, input logic [63:0] hi,
                                              input logic [3:0] k);
    logic [63:0] w;
    w = k[3] ? hi : lo;
    return w[{k[2:0], 3'b000} +: 8];
  endfunction

endpackage

// File: rtl/core/text_substring_search_core.sv
// Top level of the streaming substring search core.
// Result path: the final text word passes through s0 and s1, then its result is registered at the output.
// Throughput: one text word per cycle; the input stalls only while a finished result
// waits at the output and the next final word is ready to overwrite it.
// Reset: synchronous active-low rst_n clears pipeline, stream state and registers
// (case_sensitive resets to 1, all others to 0).
`include "text_substring_search_core_defines.svh"

module text_substring_search_core (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [7:0]                  in_text_byte,
  input  logic                        in_last_byte,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic                        out_found,
  output logic [tss_pkg::POS_W-1:0]   out_match_start,
  output logic                        out_too_long,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [tss_pkg::ADDR_W-1:0]  paddr,
  input  logic [tss_pkg::DATA_W-1:0]  pwdata,
  output logic [tss_pkg::DATA_W-1:0]  prdata,
  output logic                        pready
);

  // configuration registers
  logic [63:0]                       pat_lo_r, pat_hi_r;
  logic [tss_pkg::PAT_LEN_W-1:0]     pat_len_r;
  logic                              case_sens_r, backward_r, wrap_r;
  logic [tss_pkg::CNT_W-1:0]         sel_start_r, sel_end_r;
  tss_pkg::cfg_reg_t                 reg_sel;
  logic                              cfg_wr;

  // pipeline
  logic                              adv;
  logic                              s0_valid_r;
  logic [7:0]                        s0_byte_r;
  logic                              s0_last_r;
  logic                              s1_valid_r;
  tss_pkg::s1_word_t                 s1_r, s1_nxt;

  // stream state
  logic [tss_pkg::PATTERN_MAX-1:0][7:0] window_r, window_nxt;
  logic [tss_pkg::CNT_W-1:0]         count_r, count_nxt, cnt_inc;
  logic                              ovf_seen_r;
  tss_pkg::hit_t                     fa_r, ffs_r, fbs_r, lbs_r, las_r, la_r;
  tss_pkg::hit_t                     fa_nxt, ffs_nxt, fbs_nxt, lbs_nxt, las_nxt, la_nxt;
  tss_pkg::hit_t                     pick;
  logic                              ovf_any;

  // output register
  logic                              out_valid_r;
  logic                              out_found_r;
  logic [tss_pkg::POS_W-1:0]         out_pos_r;
  logic                              out_too_long_r;

  assign pready  = 1'b1;
  assign reg_sel = tss_pkg::cfg_reg_t'(paddr[tss_pkg::ADDR_W-1:3]);
  assign cfg_wr  = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pat_lo_r    <= '0;
      pat_hi_r    <= '0;
      pat_len_r   <= '0;
      case_sens_r <= 1'b1;
      backward_r  <= 1'b0;
      wrap_r      <= 1'b0;
      sel_start_r <= '0;
      sel_end_r   <= '0;
    end else if (cfg_wr) begin
      unique case (reg_sel)
        tss_pkg::REG_PAT_LO:    pat_lo_r    <= pwdata;
        tss_pkg::REG_PAT_HI:    pat_hi_r    <= pwdata;
        tss_pkg::REG_PAT_LEN:   pat_len_r   <= pwdata[tss_pkg::PAT_LEN_W-1:0];
        tss_pkg::REG_CASE_SENS: case_sens_r <= pwdata[0];
        tss_pkg::REG_BACKWARD:  backward_r  <= pwdata[0];
        tss_pkg::REG_WRAP:      wrap_r      <= pwdata[0];
        tss_pkg::REG_SEL_START: sel_start_r <= pwdata[tss_pkg::CNT_W-1:0];
        tss_pkg::REG_SEL_END:   sel_end_r   <= pwdata[tss_pkg::CNT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      tss_pkg::REG_PAT_LO:    prdata = pat_lo_r;
      tss_pkg::REG_PAT_HI:    prdata = pat_hi_r;
      tss_pkg::REG_PAT_LEN:   prdata = {{(tss_pkg::DATA_W-tss_pkg::PAT_LEN_W){1'b0}}, pat_len_r};
      tss_pkg::REG_CASE_SENS: prdata = {{(tss_pkg::DATA_W-1){1'b0}}, case_sens_r};
      tss_pkg::REG_BACKWARD:  prdata = {{(tss_pkg::DATA_W-1){1'b0}}, backward_r};
      tss_pkg::REG_WRAP:      prdata = {{(tss_pkg::DATA_W-1){1'b0}}, wrap_r};
      tss_pkg::REG_SEL_START: prdata = {{(tss_pkg::DATA_W-tss_pkg::CNT_W){1'b0}}, sel_start_r};
      tss_pkg::REG_SEL_END:   prdata = {{(tss_pkg::DATA_W-tss_pkg::CNT_W){1'b0}}, sel_end_r};
      default:                prdata = '0;
    endcase
  end

  // whole pipe holds only when a final word would overwrite an unread result
  assign adv      = !(s1_valid_r && s1_r.last && out_valid_r && !out_ready);
  assign in_ready = adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_valid_r <= 1'b0;
      s1_valid_r <= 1'b0;
    end else if (adv) begin
      s0_valid_r <= in_valid;
      s1_valid_r <= s0_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s0_byte_r <= in_text_byte;
      s0_last_r <= in_last_byte;
      s1_r      <= s1_nxt;
    end
  end

  // stage 1: window shift and compare
  always_comb begin
    logic [tss_pkg::PATTERN_MAX-1:0][7:0] win_sh;
    logic [tss_pkg::CNT_W-1:0]            cnt_cur;
    logic [tss_pkg::CNT_W-1:0]            start_full;
    logic [tss_pkg::WIN_IDX_W-1:0]        wi;
    logic                                 len_ok;
    logic                                 eq_all;
    logic                                 ovf;

    ovf     = (count_r >= tss_pkg::CNT_W'(tss_pkg::TEXT_MAX));
    cnt_inc = count_r + tss_pkg::CNT_W'(1);
    win_sh  = {window_r[tss_pkg::PATTERN_MAX-2:0], s0_byte_r};
    cnt_cur = ovf ? count_r : cnt_inc;

    len_ok = (pat_len_r != '0) && (pat_len_r <= tss_pkg::PAT_LEN_W'(tss_pkg::PAT_BYTES)) &&
             (pat_len_r <= tss_pkg::PAT_LEN_W'(tss_pkg::PATTERN_MAX)) &&
             (cnt_inc >= {{(tss_pkg::CNT_W-tss_pkg::PAT_LEN_W){1'b0}}, pat_len_r});
    eq_all = 1'b1;
    for (int k = 0; k < tss_pkg::PATTERN_MAX; k++) begin
      wi = tss_pkg::WIN_IDX_W'(pat_len_r - tss_pkg::PAT_LEN_W'(1) - tss_pkg::PAT_LEN_W'(k));
      if (tss_pkg::PAT_LEN_W'(k) < pat_len_r) begin
        if (tss_pkg::fold_byte(win_sh[wi], case_sens_r) !=
            tss_pkg::fold_byte(tss_pkg::pattern_byte(pat_lo_r, pat_hi_r, 4'(k)), case_sens_r)) begin
          eq_all = 1'b0;
        end
      end
    end

    start_full = cnt_inc - {{(tss_pkg::CNT_W-tss_pkg::PAT_LEN_W){1'b0}}, pat_len_r};

    s1_nxt.hit          = !ovf && len_ok && eq_all;
    s1_nxt.start        = start_full[tss_pkg::POS_W-1:0];
    s1_nxt.start_ge_end = (start_full >= sel_end_r);
    s1_nxt.end_le_end   = (cnt_inc <= sel_end_r);
    s1_nxt.end_le_start = (cnt_inc <= sel_start_r);
    s1_nxt.past_end     = (sel_end_r >= cnt_cur);
    s1_nxt.ovf          = ovf;
    s1_nxt.last         = s0_last_r;

    window_nxt = window_r;
    count_nxt  = count_r;
    if (s0_last_r) begin
      window_nxt = '0;
      count_nxt  = '0;
    end else if (!ovf) begin
      window_nxt = win_sh;
      count_nxt  = cnt_inc;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      window_r <= '0;
      count_r  <= '0;
    end else if (adv && s0_valid_r) begin
      window_r <= window_nxt;
      count_r  <= count_nxt;
    end
  end

  // stage 2: match trackers and final selection
  always_comb begin
    tss_pkg::hit_t h;
    h.valid = 1'b1;
    h.pos   = s1_r.start;

    fa_nxt  = fa_r;
    ffs_nxt = ffs_r;
    fbs_nxt = fbs_r;
    lbs_nxt = lbs_r;
    las_nxt = las_r;
    la_nxt  = la_r;
    if (s1_r.hit) begin
      if (!fa_r.valid) fa_nxt = h;
      la_nxt = h;
      if (s1_r.start_ge_end) begin
        if (!ffs_r.valid) ffs_nxt = h;
        las_nxt = h;
      end
      if (s1_r.end_le_end && !fbs_r.valid) fbs_nxt = h;
      if (s1_r.end_le_start) lbs_nxt = h;
    end

    pick = '0;
    if (!backward_r) begin
      if (wrap_r && s1_r.past_end) pick = fa_nxt;
      else if (ffs_nxt.valid)      pick = ffs_nxt;
      else if (wrap_r)             pick = fbs_nxt;
    end else begin
      if (wrap_r && sel_start_r == '0) pick = la_nxt;
      else if (lbs_nxt.valid)          pick = lbs_nxt;
      else if (wrap_r)                 pick = las_nxt;
    end
    ovf_any = ovf_seen_r || s1_r.ovf;
    if (ovf_any || !pick.valid) pick = '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fa_r       <= '0;
      ffs_r      <= '0;
      fbs_r      <= '0;
      lbs_r      <= '0;
      las_r      <= '0;
      la_r       <= '0;
      ovf_seen_r <= 1'b0;
    end else if (adv && s1_valid_r) begin
      if (s1_r.last) begin
        fa_r       <= '0;
        ffs_r      <= '0;
        fbs_r      <= '0;
        lbs_r      <= '0;
        las_r      <= '0;
        la_r       <= '0;
        ovf_seen_r <= 1'b0;
      end else begin
        fa_r       <= fa_nxt;
        ffs_r      <= ffs_nxt;
        fbs_r      <= fbs_nxt;
        lbs_r      <= lbs_nxt;
        las_r      <= las_nxt;
        la_r       <= la_nxt;
        ovf_seen_r <= ovf_any;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv && s1_valid_r && s1_r.last) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && s1_valid_r && s1_r.last) begin
      out_found_r    <= pick.valid;
      out_pos_r      <= pick.pos;
      out_too_long_r <= ovf_any;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_found       = out_found_r;
  assign out_match_start = out_pos_r;
  assign out_too_long    = out_too_long_r;

  `TSS_ASSERT_RUN(a_stall_on_full_out, clk, rst_n, (s1_valid_r && s1_r.last && out_valid_r && !out_ready) |-> !in_ready, "input taken while final word blocked")
  `TSS_ASSERT_RUN(a_result_follows_last, clk, rst_n, (adv && s1_valid_r && s1_r.last) |=> out_valid_r, "final word gave no result")
  `TSS_ASSERT_RUN(a_count_in_range, clk, rst_n, count_r <= tss_pkg::CNT_W'(tss_pkg::TEXT_MAX), "byte count beyond text range")
  `TSS_ASSERT_RUN(a_overflow_not_found, clk, rst_n, (out_valid_r && out_too_long_r) |-> (!out_found_r && out_pos_r == '0), "match reported on overlong text")

endmodule
